>>> sv/csm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csm_pkg
// Shared types and constants of the command-line signature matcher: the
// literal signatures, their found-flag positions and the verdict codes.
// ----------------------------------------------------------------------------
package csm_pkg;

  // Bytes beyond this count on one line are ignored.
  localparam int MAX_BYTES  = 8192;
  localparam int CNT_W      = $clog2(MAX_BYTES + 1);

  // History window, newest byte included; the longest signature fills it.
  localparam int HIST_DEPTH = 47;
  localparam int HIST_BITS  = 8 * HIST_DEPTH;

  localparam int SIG_COUNT  = 12;
  localparam int FLAG_COUNT = 7;

  // Room for the first-token length, which saturates at five.
  localparam int TOK_LEN_MAX = 5;
  localparam int TOK_LEN_W   = $clog2(TOK_LEN_MAX + 1);

  typedef logic [7:0]            byte_t;
  typedef logic [CNT_W-1:0]      count_t;
  typedef logic [TOK_LEN_W-1:0]  tok_len_t;
  typedef logic [FLAG_COUNT-1:0] flags_t;
  typedef logic [HIST_BITS-1:0]  window_t;
  typedef logic [2:0]            flag_idx_t;

  typedef enum logic [1:0] {
    RULE_NONE   = 2'd0,
    RULE_STRONG = 2'd1,
    RULE_BRAND  = 2'd2,
    RULE_LAYOUT = 2'd3
  } rule_t;

  localparam flag_idx_t FLAG_STRONG     = 3'd0;
  localparam flag_idx_t FLAG_BRAND      = 3'd1;
  localparam flag_idx_t FLAG_GAME_DIR   = 3'd2;
  localparam flag_idx_t FLAG_ASSETS_DIR = 3'd3;
  localparam flag_idx_t FLAG_DOT_DIR    = 3'd4;
  localparam flag_idx_t FLAG_ASSET_IDX  = 3'd5;
  localparam flag_idx_t FLAG_VER_TYPE   = 3'd6;

  localparam flags_t BRAND_MASK  = 7'h0E;
  localparam flags_t LAYOUT_MASK = 7'h7C;

  localparam byte_t    NUL_BYTE   = 8'h00;
  localparam byte_t    SLASH_BYTE = 8'h2F;
  localparam logic [31:0] JAVA_TEXT = "java";
  localparam tok_len_t JAVA_LEN   = TOK_LEN_W'(4);

  // Signatures are right-aligned: the last character sits in bits [7:0], so
  // each one compares directly against the low bytes of the history window.
  localparam window_t SIG_TEXT [SIG_COUNT] = '{
    HIST_BITS'({"-Dmine", "craft.client.jar="}),
    HIST_BITS'({"net.fabric", "mc.loader.impl.launch.knot.KnotClient"}),
    HIST_BITS'({"org.quilt", "mc.loader.impl.launch.knot.KnotClient"}),
    HIST_BITS'({"net.mine", "craft.client.main.Main"}),
    HIST_BITS'({"net.mine", "craft.launchwrapper.Launch"}),
    HIST_BITS'({"cp", "w.mods.modlauncher.Launcher"}),
    HIST_BITS'({"-Dmine", "craft.launcher.brand="}),
    HIST_BITS'("--gameDir"),
    HIST_BITS'("--assetsDir"),
    HIST_BITS'({".mine", "craft/"}),
    HIST_BITS'("--assetIndex"),
    HIST_BITS'("--versionType")
  };

  localparam int SIG_LEN [SIG_COUNT] = '{23, 47, 46, 30, 34, 29, 27, 9, 11, 11, 12, 13};

  localparam flag_idx_t SIG_FLAG [SIG_COUNT] = '{
    FLAG_STRONG, FLAG_STRONG, FLAG_STRONG, FLAG_STRONG, FLAG_STRONG, FLAG_STRONG,
    FLAG_BRAND, FLAG_GAME_DIR, FLAG_ASSETS_DIR, FLAG_DOT_DIR, FLAG_ASSET_IDX,
    FLAG_VER_TYPE
  };

  // Byte mask covering the lowest n bytes of the window.
  function automatic window_t len_mask(int n);
    window_t m;
    m = '0;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      if (i < n) begin
        m[8*i +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

>>> sv/csm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csm_if
// Valid/ready channels of the matcher: command-line bytes in, verdicts out.
// ----------------------------------------------------------------------------
interface csm_in_if;
  logic               valid;
  logic               ready;
  csm_pkg::byte_t     data_byte;
  logic               is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface csm_out_if;
  logic               valid;
  logic               ready;
  logic               is_target;
  logic               program_is_java;
  csm_pkg::rule_t     matched_rule;

  modport source (output valid, output is_target, output program_is_java,
                  output matched_rule, input ready);
  modport sink   (input valid, input is_target, input program_is_java,
                  input matched_rule, output ready);
endinterface

>>> sv/cmdline_signature_matcher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmdline_signature_matcher_unit
// Streaming classifier of a process command line against fixed signatures.
// ----------------------------------------------------------------------------
// One command-line byte is taken per clock cycle, and the beat that carries
// is_last yields one verdict beat on the output channel in the next cycle; other
// beats yield nothing. Each byte is compared in the same cycle against all
// twelve signatures over the history register, so the rate is one byte per
// cycle as long as the output side takes its verdicts; the input stalls only
// while a verdict is held and the output is not ready. After a verdict all
// state is back at its reset value, ready for the next line.
// ----------------------------------------------------------------------------
module cmdline_signature_matcher_unit (
  input  logic clk,
  input  logic rst,
  csm_in_if.sink    cmd,
  csm_out_if.source verdict
);
  import csm_pkg::*;

  // The newest byte arrives on the input, so only the older bytes are held.
  byte_t    hist [HIST_DEPTH-1];
  count_t   bytes_seen;
  logic     tok_done;
  tok_len_t tok_len;
  logic     tok_java;
  flags_t   found;

  logic     tok_done_next;
  tok_len_t tok_len_next;
  logic     tok_java_next;
  flags_t   found_next;

  logic     out_valid;
  logic     out_target;
  logic     out_java;
  rule_t    out_rule;

  logic     accept;
  logic     in_range;
  window_t  window;
  logic [SIG_COUNT-1:0] sig_hit;
  flags_t   hit_flags;
  rule_t    rule_next;

  assign cmd.ready = !out_valid || verdict.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign in_range  = bytes_seen < count_t'(MAX_BYTES);

  always_comb begin
    window[7:0] = cmd.data_byte;
    for (int i = 0; i < HIST_DEPTH - 1; i++) begin
      window[8*(i+1) +: 8] = hist[i];
    end
  end

  for (genvar k = 0; k < SIG_COUNT; k++) begin : g_sig
    localparam window_t Mask = len_mask(SIG_LEN[k]);
    assign sig_hit[k] = ((window ^ SIG_TEXT[k]) & Mask) == '0;
  end

  always_comb begin
    hit_flags = '0;
    for (int k = 0; k < SIG_COUNT; k++) begin
      if (sig_hit[k]) begin
        hit_flags[SIG_FLAG[k]] = 1'b1;
      end
    end
  end

  // First-token tracking and sticky flags, as they stand after this byte.
  always_comb begin
    tok_done_next = tok_done;
    tok_len_next  = tok_len;
    tok_java_next = tok_java;
    found_next    = found;
    if (in_range) begin
      found_next = found | hit_flags;
      if (!tok_done) begin
        if (cmd.data_byte == NUL_BYTE) begin
          tok_done_next = 1'b1;
        end else begin
          if (tok_len < tok_len_t'(TOK_LEN_MAX)) begin
            tok_len_next = tok_len + tok_len_t'(1);
          end
          // hist[3] is the fifth byte back once this one is counted.
          tok_java_next = (window[31:0] == JAVA_TEXT) &&
                          (tok_len_next == JAVA_LEN || hist[3] == SLASH_BYTE);
        end
      end
    end
  end

  always_comb begin
    rule_next = RULE_NONE;
    if (tok_java_next) begin
      if (found_next[FLAG_STRONG]) begin
        rule_next = RULE_STRONG;
      end else if ((found_next & BRAND_MASK) == BRAND_MASK) begin
        rule_next = RULE_BRAND;
      end else if ((found_next & LAYOUT_MASK) == LAYOUT_MASK) begin
        rule_next = RULE_LAYOUT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && cmd.is_last)) begin
      for (int i = 0; i < HIST_DEPTH - 1; i++) begin
        hist[i] <= '0;
      end
      bytes_seen <= '0;
      tok_done   <= 1'b0;
      tok_len    <= '0;
      tok_java   <= 1'b0;
      found      <= '0;
    end else if (accept && in_range) begin
      hist[0] <= cmd.data_byte;
      for (int i = 1; i < HIST_DEPTH - 1; i++) begin
        hist[i] <= hist[i-1];
      end
      bytes_seen <= bytes_seen + count_t'(1);
      tok_done   <= tok_done_next;
      tok_len    <= tok_len_next;
      tok_java   <= tok_java_next;
      found      <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && cmd.is_last) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd.is_last) begin
      out_target <= rule_next != RULE_NONE;
      out_java   <= tok_java_next;
      out_rule   <= rule_next;
    end
  end

  assign verdict.valid           = out_valid;
  assign verdict.is_target       = out_target;
  assign verdict.program_is_java = out_java;
  assign verdict.matched_rule    = out_rule;

  // A new verdict beat only follows a final byte.
  a_verdict_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(accept && cmd.is_last))
    else $error("verdict raised without a final byte");

  // A qualifying verdict always names a rule and a java program.
  a_target_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_target == (out_rule != RULE_NONE)) &&
                  (!out_target || out_java))
    else $error("verdict fields disagree");

  // The final byte returns the line state to its reset value.
  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.is_last |=> bytes_seen == '0 && found == '0 && !tok_done &&
                              !tok_java)
    else $error("line state not cleared after final byte");

  // The byte count never passes its limit.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    bytes_seen <= count_t'(MAX_BYTES))
    else $error("byte count past limit");

endmodule
